[sv/pwe_pkg.sv]
// Shared types, constants and coefficient tables for the piecewise width estimator.
package pwe_pkg;

  typedef enum logic {
    FOP_MUL,
    FOP_ADD
  } fpu_op_e;

  typedef enum logic [1:0] {
    PC_LO,
    PC_MID,
    PC_HI
  } piece_e;

  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  localparam logic [63:0] QNAN_BITS  = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT  = 64'h0008_0000_0000_0000;
  localparam logic [63:0] FLOOR_BITS = $realtobits(0.00215708);
  localparam logic [63:0] EDGE_LO    = 64'h4056_8000_0000_0000;
  localparam logic [63:0] EDGE_MID   = 64'h4063_9000_0000_0000;
  localparam logic [63:0] EDGE_HI    = 64'h4064_4000_0000_0000;

  localparam logic [3:0] DEG_LO  = 4'd9;
  localparam logic [3:0] DEG_MID = 4'd3;
  localparam logic [3:0] DEG_HI  = 4'd10;

  localparam logic [63:0] LO_C [10] = '{
    $realtobits(-1.450308902710193E+03), $realtobits(1.129291251156317E+02),
    $realtobits(-3.893063071316150E+00), $realtobits(7.798666884832531E-02),
    $realtobits(-1.000455877406390E-03), $realtobits(8.523735379647125E-06),
    $realtobits(-4.823164754652171E-08), $realtobits(1.747954506786346E-10),
    $realtobits(-3.681723572169337E-13), $realtobits(3.434207075968898E-16)
  };

  localparam logic [63:0] HI_C [11] = '{
    $realtobits(2.563291882845993E+02), $realtobits(-1.037082025855304E+01),
    $realtobits(1.780260502696301E-01), $realtobits(-1.720311784419889E-03),
    $realtobits(1.038418605369741E-05), $realtobits(-4.092496883922424E-08),
    $realtobits(1.067667966800388E-10), $realtobits(-1.823343280081685E-13),
    $realtobits(1.955637395597351E-16), $realtobits(-1.193287048560413E-19),
    $realtobits(3.156196649452213E-23)
  };

  localparam logic [63:0] MID_C [4] = '{
    $realtobits(-5.255605465437446E+02), $realtobits(1.036972988796150E+01),
    $realtobits(-6.817022987365029E-02), $realtobits(1.493275723660056E-04)
  };

  function automatic logic [63:0] coef(piece_e p, logic [3:0] k);
    logic [63:0] r;
    r = '0;
    unique case (p)
      PC_LO:   r = (k <= DEG_LO) ? LO_C[k] : '0;
      PC_MID:  r = (k <= DEG_MID) ? MID_C[k[1:0]] : '0;
      PC_HI:   r = (k <= DEG_HI) ? HI_C[k] : '0;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/pwe_fpu.sv]
// Multi-cycle binary64 multiply and add unit with round to nearest even.
module pwe_fpu import pwe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fpu_req_t    req_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ALIGN,
    F_ADD,
    F_NORM,
    F_DENORM,
    F_ROUND
  } fstate_e;

  fstate_e            state_q;
  logic               done_q;
  logic [63:0]        res_q;
  logic               s_q;
  logic               sub_q;
  logic               tiny_q;
  logic signed [13:0] e_q;
  logic [127:0]       w_q;
  logic [127:0]       x_q;
  logic [52:0]        ma_q;
  logic [52:0]        mb_q;
  logic [1:0]         cnt_q;
  logic [6:0]         dsh_q;

  logic [10:0]        exa, exb;
  logic [52:0]        mana, manb;
  logic signed [13:0] eua, eub, dexp;
  logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_big;

  logic [26:0]        pa, pb;
  logic [53:0]        pp;
  logic [6:0]         pshift;

  logic [127:0]       xs, xmask;
  logic signed [13:0] bexp, dsh;
  logic [6:0]         dsh7;
  logic [127:0]       wmask;

  logic [52:0]        mant;
  logic               rinc;
  logic [53:0]        rsum;
  logic signed [13:0] bn;

  always_comb begin
    exa    = req_i.a[62:52];
    exb    = req_i.b[62:52];
    mana   = {exa != 11'd0, req_i.a[51:0]};
    manb   = {exb != 11'd0, req_i.b[51:0]};
    eua    = (exa == 11'd0) ? -14'sd1022 : $signed({3'b000, exa}) - 14'sd1023;
    eub    = (exb == 11'd0) ? -14'sd1022 : $signed({3'b000, exb}) - 14'sd1023;
    nan_a  = (exa == 11'h7FF) && (req_i.a[51:0] != 52'd0);
    nan_b  = (exb == 11'h7FF) && (req_i.b[51:0] != 52'd0);
    inf_a  = (exa == 11'h7FF) && (req_i.a[51:0] == 52'd0);
    inf_b  = (exb == 11'h7FF) && (req_i.b[51:0] == 52'd0);
    zero_a = req_i.a[62:0] == 63'd0;
    zero_b = req_i.b[62:0] == 63'd0;
    a_big  = req_i.a[62:0] >= req_i.b[62:0];
    dexp   = a_big ? (eua - eub) : (eub - eua);

    pa     = cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
    pb     = cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
    pp     = pa * pb;
    pshift = 7'd22 + (cnt_q[1] ? 7'd27 : 7'd0) + (cnt_q[0] ? 7'd27 : 7'd0);

    xs     = {1'b0, mb_q, 74'd0};
    xmask  = ~({128{1'b1}} << dsh_q);

    bexp   = e_q + 14'sd1023;
    dsh    = 14'sd1 - bexp;
    dsh7   = (dsh > 14'sd127) ? 7'd127 : dsh[6:0];
    wmask  = ~({128{1'b1}} << dsh7);

    mant   = w_q[127:75];
    rinc   = w_q[74] & ((|w_q[73:0]) | mant[0]);
    rsum   = {1'b0, mant} + {53'd0, rinc};
    bn     = e_q + {13'd0, rsum[53]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
      s_q     <= 1'b0;
      sub_q   <= 1'b0;
      tiny_q  <= 1'b0;
      e_q     <= '0;
      w_q     <= '0;
      x_q     <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      cnt_q   <= '0;
      dsh_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            cnt_q <= '0;
            if (req_i.op == FOP_MUL) begin
              s_q   <= req_i.a[63] ^ req_i.b[63];
              sub_q <= 1'b0;
              if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
                res_q  <= QNAN_BITS;
                done_q <= 1'b1;
              end else if (inf_a || inf_b) begin
                res_q  <= {req_i.a[63] ^ req_i.b[63], 11'h7FF, 52'd0};
                done_q <= 1'b1;
              end else if (zero_a || zero_b) begin
                res_q  <= {req_i.a[63] ^ req_i.b[63], 63'd0};
                done_q <= 1'b1;
              end else begin
                ma_q    <= mana;
                mb_q    <= manb;
                e_q     <= eua + eub + 14'sd1;
                w_q     <= '0;
                state_q <= F_MUL;
              end
            end else begin
              if (nan_a || nan_b || (inf_a && inf_b && (req_i.a[63] != req_i.b[63]))) begin
                res_q  <= QNAN_BITS;
                done_q <= 1'b1;
              end else if (inf_a) begin
                res_q  <= req_i.a;
                done_q <= 1'b1;
              end else if (inf_b) begin
                res_q  <= req_i.b;
                done_q <= 1'b1;
              end else begin
                s_q     <= a_big ? req_i.a[63] : req_i.b[63];
                sub_q   <= req_i.a[63] ^ req_i.b[63];
                w_q     <= {1'b0, (a_big ? mana : manb), 74'd0};
                mb_q    <= a_big ? manb : mana;
                e_q     <= (a_big ? eua : eub) + 14'sd1;
                dsh_q   <= (dexp > 14'sd127) ? 7'd127 : dexp[6:0];
                state_q <= F_ALIGN;
              end
            end
          end
        end
        F_MUL: begin
          w_q   <= w_q + ({74'd0, pp} << pshift);
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= F_NORM;
          end
        end
        F_ALIGN: begin
          x_q     <= (xs >> dsh_q) | {127'd0, |(xs & xmask)};
          state_q <= F_ADD;
        end
        F_ADD: begin
          w_q     <= sub_q ? (w_q - x_q) : (w_q + x_q);
          state_q <= F_NORM;
        end
        F_NORM: begin
          if (w_q == '0) begin
            res_q   <= {(sub_q ? 1'b0 : s_q), 63'd0};
            done_q  <= 1'b1;
            state_q <= F_IDLE;
          end else if (w_q[127]) begin
            state_q <= F_DENORM;
          end else if (w_q[127:112] == 16'd0) begin
            w_q <= w_q << 16;
            e_q <= e_q - 14'sd16;
          end else begin
            w_q <= w_q << 1;
            e_q <= e_q - 14'sd1;
          end
        end
        F_DENORM: begin
          if (bexp <= 14'sd0) begin
            w_q    <= (w_q >> dsh7) | {127'd0, |(w_q & wmask)};
            tiny_q <= 1'b1;
            e_q    <= '0;
          end else begin
            tiny_q <= 1'b0;
            e_q    <= bexp;
          end
          state_q <= F_ROUND;
        end
        F_ROUND: begin
          if (tiny_q) begin
            res_q <= {s_q, 10'd0, rsum[52], rsum[51:0]};
          end else if (bn >= 14'sd2047) begin
            res_q <= {s_q, 11'h7FF, 52'd0};
          end else begin
            res_q <= {s_q, bn[10:0], (rsum[53] ? rsum[52:1] : rsum[51:0])};
          end
          done_q  <= 1'b1;
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[sv/piecewise_poly_width_estimate.sv]
// Top level of the piecewise polynomial width estimator.
// One word in, one word out; a new word is taken only while the sequencer is idle.
// NaN and below-range words skip the Horner steps and go from selection straight to output.
// Otherwise each Horner step is a multiply, then an add, on the shared binary64 unit;
// the low, middle and high pieces have degree 9, 3 and 10.
// Reset is asynchronous and active low and clears the sequencer and output valid.
module piecewise_poly_width_estimate import pwe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] mass_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [63:0] width_bits
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEL,
    S_MUL,
    S_WMUL,
    S_ADD,
    S_WADD,
    S_OUT
  } state_e;

  state_e      state_q;
  logic [63:0] m_q;
  logic [63:0] acc_q;
  piece_e      sel_q;
  logic [3:0]  k_q;
  logic        out_valid_q;
  logic [63:0] out_data_q;

  fpu_req_t    req;
  logic        fpu_done;
  logic [63:0] fpu_res;
  logic        is_nan;

  assign is_nan = (m_q[62:52] == 11'h7FF) && (m_q[51:0] != 52'd0);

  always_comb begin
    req.start = (state_q == S_MUL) || (state_q == S_ADD);
    req.op    = (state_q == S_ADD) ? FOP_ADD : FOP_MUL;
    req.a     = acc_q;
    req.b     = (state_q == S_ADD) ? coef(sel_q, k_q) : m_q;
  end

  pwe_fpu u_fpu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .done_o   (fpu_done),
    .result_o (fpu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      m_q         <= '0;
      acc_q       <= '0;
      sel_q       <= PC_LO;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            m_q     <= s_axis_tdata_i;
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          priority if (is_nan) begin
            acc_q   <= m_q | QUIET_BIT;
            state_q <= S_OUT;
          end else if (m_q[63] || (m_q < EDGE_LO)) begin
            acc_q   <= FLOOR_BITS;
            state_q <= S_OUT;
          end else if (m_q < EDGE_MID) begin
            sel_q   <= PC_LO;
            k_q     <= DEG_LO;
            acc_q   <= coef(PC_LO, DEG_LO);
            state_q <= S_MUL;
          end else if (m_q <= EDGE_HI) begin
            sel_q   <= PC_MID;
            k_q     <= DEG_MID;
            acc_q   <= coef(PC_MID, DEG_MID);
            state_q <= S_MUL;
          end else begin
            sel_q   <= PC_HI;
            k_q     <= DEG_HI;
            acc_q   <= coef(PC_HI, DEG_HI);
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_WMUL;
        S_WMUL: begin
          if (fpu_done) begin
            acc_q   <= fpu_res;
            k_q     <= k_q - 4'd1;
            state_q <= S_ADD;
          end
        end
        S_ADD: state_q <= S_WADD;
        S_WADD: begin
          if (fpu_done) begin
            acc_q   <= fpu_res;
            state_q <= (k_q == 4'd0) ? S_OUT : S_MUL;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= acc_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[sv/pwe_checker.sv]
// Port-level checks for the width estimator, bound to the top level.
module pwe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("Input ready stayed high after a word was accepted.");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !$rose(m_axis_tvalid_o))
    else $error("Result appeared one cycle after the input word.");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("Output valid dropped before the word was taken.");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("Output word changed while stalled.");

endmodule

bind piecewise_poly_width_estimate pwe_checker u_pwe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[dv/testbench.sv]
// Self-checking testbench for the piecewise polynomial width estimator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pwe_pkg::*;

  localparam int unsigned NUM_RANDOM  = 1850;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_AT    = 40;
  localparam int unsigned CALM_FROM   = 120000;
  localparam int unsigned CALM_TO     = 170000;

  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;

  piecewise_poly_width_estimate i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  real lo_coef [10] = '{
    -1.450308902710193E+03, 1.129291251156317E+02, -3.893063071316150E+00,
    7.798666884832531E-02, -1.000455877406390E-03, 8.523735379647125E-06,
    -4.823164754652171E-08, 1.747954506786346E-10, -3.681723572169337E-13,
    3.434207075968898E-16
  };
  real hi_coef [11] = '{
    2.563291882845993E+02, -1.037082025855304E+01, 1.780260502696301E-01,
    -1.720311784419889E-03, 1.038418605369741E-05, -4.092496883922424E-08,
    1.067667966800388E-10, -1.823343280081685E-13, 1.955637395597351E-16,
    -1.193287048560413E-19, 3.156196649452213E-23
  };
  real mid_coef [4] = '{
    -5.255605465437446E+02, 1.036972988796150E+01,
    -6.817022987365029E-02, 1.493275723660056E-04
  };

  logic [63:0] mass_queue [$];
  logic [63:0] width_queue [$];
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned error_count = 0;
  logic        in_taken = 1'b0;

  function automatic logic [63:0] estimate_width(input logic [63:0] mass_bits);
    real m;
    real acc;
    real prod;
    int  k;
    if ((mass_bits[62:52] == 11'h7FF) && (mass_bits[51:0] != '0)) begin
      return mass_bits | QUIET_BIT;
    end
    m = $bitstoreal(mass_bits);
    if (m < 90.0) begin
      acc = 0.00215708;
    end else if (m < 156.5) begin
      acc = lo_coef[9];
      for (k = 8; k >= 0; k--) begin
        prod = acc * m;
        acc = prod + lo_coef[k];
      end
    end else if (m <= 162.0) begin
      acc = mid_coef[3];
      for (k = 2; k >= 0; k--) begin
        prod = acc * m;
        acc = prod + mid_coef[k];
      end
    end else begin
      acc = hi_coef[10];
      for (k = 9; k >= 0; k--) begin
        prod = acc * m;
        acc = prod + hi_coef[k];
      end
    end
    return $realtobits(acc);
  endfunction

  function automatic logic [63:0] random_mass();
    logic [63:0] edge_bits;
    real         r;
    case ($urandom_range(0, 9))
      0, 1: return {$urandom, $urandom};
      2, 3, 4, 5, 6, 7: begin
        r = 80.0 + 340.0 * ($urandom / 4294967296.0);
        return $realtobits(r) ^ {44'd0, 20'($urandom)};
      end
      8: begin
        case ($urandom_range(0, 2))
          0: edge_bits = EDGE_LO;
          1: edge_bits = EDGE_MID;
          default: edge_bits = EDGE_HI;
        endcase
        return edge_bits + 64'($urandom_range(0, 8)) - 64'd4;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, 63'($urandom) << 20} ^ {32'd0, $urandom};
          1: return {12'h7FF, 52'(1) << $urandom_range(0, 51)};
          2: return {12'hFFF, 20'($urandom), $urandom};
          3: return {1'b0, 11'($urandom_range(1028, 2046)), 20'($urandom), $urandom};
          default: return {1'b0, 11'($urandom_range(0, 1029)), 20'($urandom), $urandom};
        endcase
      end
    endcase
  endfunction

  function automatic logic idle_now();
    if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 38;
  endfunction

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    mass_queue = '{64'd0, NEG_ZERO, NEG_INF, POS_INF, 64'hC059_0000_0000_0000,
                   EDGE_LO, EDGE_LO - 64'd1, EDGE_LO + 64'd1,
                   EDGE_MID, EDGE_MID - 64'd1, EDGE_MID + 64'd1,
                   EDGE_HI, EDGE_HI - 64'd1, EDGE_HI + 64'd1,
                   $realtobits(120.0), $realtobits(159.0), $realtobits(250.0),
                   64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
                   64'h7FF0_0000_0000_0001, 64'hFFF4_0000_0000_1234,
                   QNAN_BITS, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001};
    repeat (NUM_RANDOM) mass_queue.push_back(random_mass());
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    do @(posedge clk_i);
    while (mass_queue.size() != 0 || s_axis_tvalid_i || width_queue.size() != 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Prediction on accepted input words and checking of accepted output words.
  always @(posedge clk_i) begin
    logic [63:0] want;
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      width_queue.push_back(estimate_width(s_axis_tdata_i));
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (width_queue.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, m_axis_tdata_o);
        error_count <= error_count + 1;
      end else begin
        want = width_queue.pop_front();
        if (m_axis_tdata_o !== want) begin
          $display("%0t: width_bits expected %h actual %h", $time, want, m_axis_tdata_o);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Input driver.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (mass_queue.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (sent_count == DRAIN_AT && width_queue.size() != 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (idle_now()) begin
        s_axis_tvalid_i <= 1'b0;
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= mass_queue.pop_front();
        sent_count <= sent_count + 1;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready_i <= !idle_now();
    end
  end

endmodule
